// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A clocked property that is switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// When cond holds at one edge, expr keeps its value into the next cycle.
`define ASSERT_HOLD(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(expr)) \
        else $error(msg);

`endif

// File: rtl/ipsc_pkg.sv
// Types and constants of the IPv4 prefix text scanner.
package ipsc_pkg;

    localparam int NUM_FIELDS = 5;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [7:0] PREFIX_DEFAULT = 8'd32;
    localparam logic [2:0] RUN_LIMIT      = 3'd4;
    localparam logic [2:0] DOT_LIMIT      = 3'd4;
    localparam logic [2:0] DOTS_WANTED    = 3'd3;
    localparam logic [2:0] INDEX_FULL     = 3'd6;

    typedef logic [NUM_FIELDS-1:0][7:0] t_field_vec;

    typedef struct packed {
        logic       in_candidate;
        logic [2:0] dot_count;
        logic [2:0] run_digits;
        logic [2:0] field_index;
        logic       in_run;
        t_field_vec field_values;
    } t_scan_state;

    // Field order: octets a..d in entries 0..3, the prefix in entry 4.
    localparam t_field_vec FIELDS_CLEAR = {PREFIX_DEFAULT, 8'd0, 8'd0, 8'd0, 8'd0};

    localparam t_scan_state STATE_RESET = '{
        in_candidate: 1'b0,
        dot_count:    3'd0,
        run_digits:   3'd0,
        field_index:  3'd0,
        in_run:       1'b0,
        field_values: FIELDS_CLEAR
    };

    localparam t_scan_state STATE_OPEN = '{
        in_candidate: 1'b1,
        dot_count:    3'd0,
        run_digits:   3'd0,
        field_index:  3'd0,
        in_run:       1'b0,
        field_values: FIELDS_CLEAR
    };

endpackage

// File: rtl/ipsc_if.sv
// Request channels of the scanner: text bytes in, parsed addresses out.
interface ipsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ipsc_addr_if;
    logic       valid;
    logic       ready;
    logic [7:0] octet_a;
    logic [7:0] octet_b;
    logic [7:0] octet_c;
    logic [7:0] octet_d;
    logic [7:0] prefix_len;

    modport source (output valid, output octet_a, output octet_b, output octet_c,
                    output octet_d, output prefix_len, input ready);
    modport sink   (input valid, input octet_a, input octet_b, input octet_c,
                    input octet_d, input prefix_len, output ready);
endinterface

// File: rtl/ipsc_step.sv
// Next-state logic of the scanner for one text byte.
module ipsc_step (
    input  ipsc_pkg::t_scan_state i_state,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_end_of_text,
    output ipsc_pkg::t_scan_state o_state,
    output logic                  o_emit
);
    import ipsc_pkg::*;

    logic        is_digit;
    logic [3:0]  digit_val;
    logic        active;
    logic        close;
    t_scan_state base;
    t_scan_state nxt;

    always_comb begin
        is_digit  = i_text_byte inside {[CH_ZERO:CH_NINE]};
        digit_val = 4'(i_text_byte - CH_ZERO);
        active    = i_state.in_candidate | is_digit;
        // A digit outside a candidate opens a fresh one.
        base      = i_state.in_candidate ? i_state : STATE_OPEN;
        nxt       = base;
        close     = 1'b0;

        if (!active) begin
            nxt = i_state;
        end else if (is_digit) begin
            nxt.run_digits = base.run_digits + 3'd1;
            for (int k = 0; k < NUM_FIELDS; k++) begin
                if (!base.in_run) begin
                    if (base.field_index == 3'(k)) begin
                        nxt.field_values[k] = {4'd0, digit_val};
                    end
                end else if (base.field_index == 3'(k + 1)) begin
                    // Decimal accumulate, value * 10 + digit, modulo 256.
                    nxt.field_values[k] = {base.field_values[k][4:0], 3'b000}
                                        + {base.field_values[k][6:0], 1'b0}
                                        + {4'd0, digit_val};
                end
            end
            if (!base.in_run && base.field_index < INDEX_FULL) begin
                nxt.field_index = base.field_index + 3'd1;
            end
            nxt.in_run = 1'b1;
            if (nxt.run_digits >= RUN_LIMIT) begin
                close = 1'b1;
            end
        end else if (i_text_byte == CH_DOT) begin
            nxt.dot_count  = base.dot_count + 3'd1;
            nxt.run_digits = 3'd0;
            nxt.in_run     = 1'b0;
            if (nxt.dot_count >= DOT_LIMIT) begin
                close = 1'b1;
            end
        end else if (i_text_byte == CH_SLASH) begin
            nxt.run_digits = 3'd1;
            nxt.in_run     = 1'b0;
        end else begin
            close = 1'b1;
        end

        if (active && i_end_of_text) begin
            close = 1'b1;
        end

        if (close) begin
            nxt.in_candidate = 1'b0;
            nxt.in_run       = 1'b0;
        end

        o_emit  = close && (nxt.dot_count == DOTS_WANTED);
        o_state = nxt;
    end

endmodule

// File: rtl/ipv4_prefix_text_scanner.sv
// Top level of the IPv4 dotted-quad and prefix text scanner.
//
//   Channel   Direction   Payload                                     Per request
//   i_in      in          text_byte[7:0], end_of_text                 one text byte
//   o_out     out         octet_a..octet_d[7:0], prefix_len[7:0]      one found address
//
// A byte is taken into the input register, and when the scan stage advances the scan
// state is updated and any finished address is loaded into the output register. One
// byte is accepted every cycle while the output register is not stalled.
// Only the output register can stall; while its address is not taken, the input
// register takes at most one more byte and holds it, and input ready then drops.
// Reset is synchronous and active low; it empties both registers, closes any open
// candidate and keeps input ready low.
module ipv4_prefix_text_scanner (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ipsc_byte_if.sink          i_in,
    ipsc_addr_if.source        o_out
);
    import ipsc_pkg::*;

    // Input register stage.
    logic        r_in_valid;
    logic [7:0]  r_text_byte;
    logic        r_end_of_text;

    // Scan state carried from byte to byte.
    t_scan_state r_state;
    t_scan_state n_state;
    logic        n_emit;

    // Output register stage.
    logic        r_out_valid;
    t_field_vec  r_fields;

    logic        advance;
    logic        in_ready;

    // The scan stage moves whenever the output register is free or being emptied.
    // No request is taken while reset is held.
    assign advance  = !r_out_valid || o_out.ready;
    assign in_ready = i_rst_n && (!r_in_valid || advance);

    ipsc_step u_step (
        .i_state       (r_state),
        .i_text_byte   (r_text_byte),
        .i_end_of_text (r_end_of_text),
        .o_state       (n_state),
        .o_emit        (n_emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && n_emit;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_text_byte   <= i_in.text_byte;
            r_end_of_text <= i_in.end_of_text;
        end
        if (advance && r_in_valid && n_emit) begin
            r_fields <= n_state.field_values;
        end
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.octet_a    = r_fields[0];
    assign o_out.octet_b    = r_fields[1];
    assign o_out.octet_c    = r_fields[2];
    assign o_out.octet_d    = r_fields[3];
    assign o_out.prefix_len = r_fields[4];

endmodule

// File: rtl/ipsc_checker.sv
// Port-level checker of the scanner and its bind to the top level.
`include "assert_macros.svh"

module ipsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_octet_a,
    input logic [7:0] i_octet_b,
    input logic [7:0] i_octet_c,
    input logic [7:0] i_octet_d,
    input logic [7:0] i_prefix_len
);

    // With the output register empty, nothing can hold back the input.
    `ASSERT_CLK(a_ready_when_out_empty, i_clk, i_rst_n, !i_out_valid |-> i_in_ready, "input stalled with empty output")

    // A new address appears once the byte that closed it has passed the input register and the output register.
    `ASSERT_CLK(a_result_latency, i_clk, i_rst_n, (i_out_valid && !$past(i_out_valid)) |-> $past(i_in_valid && i_in_ready, 2), "address without a byte two cycles before")

    // A stalled address keeps its valid and all of its fields.
    `ASSERT_CLK(a_out_valid_holds, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid, "address dropped while stalled")
    `ASSERT_HOLD(a_out_fields_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, {i_octet_a, i_octet_b, i_octet_c, i_octet_d, i_prefix_len}, "address changed while stalled")

endmodule

bind ipv4_prefix_text_scanner ipsc_checker u_ipsc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_octet_a    (o_out.octet_a),
    .i_octet_b    (o_out.octet_b),
    .i_octet_c    (o_out.octet_c),
    .i_octet_d    (o_out.octet_d),
    .i_prefix_len (o_out.prefix_len)
);
